[src/tdp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tdp_pkg;

   localparam int unsigned REQ_NUMBER_WIDTH = 32;
   localparam int unsigned RSP_DIVISOR_WIDTH = 16;
   localparam int unsigned FIRST_DIVISOR = 2;

   typedef struct packed {
      logic load;
      logic div_start;
      logic div_step;
      logic next_div;
      logic out_load;
      logic out_prime;
   } tdp_cmd_type;

   typedef struct packed {
      logic below_two;
      logic past_root;
      logic div_last;
      logic rem_zero;
   } tdp_status_type;

endpackage

`default_nettype wire

[src/tdp_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdp_datapath
   import tdp_pkg::*;
#(
   parameter int unsigned NUM_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic [REQ_NUMBER_WIDTH-1:0]  req_number,
   input  wire tdp_cmd_type                  cmd,
   output tdp_status_type                    status,
   output logic                              rsp_is_prime,
   output logic [RSP_DIVISOR_WIDTH-1:0]      rsp_least_divisor
);

   localparam int unsigned EW = (NUM_WIDTH < REQ_NUMBER_WIDTH) ? NUM_WIDTH : REQ_NUMBER_WIDTH;
   localparam int unsigned DW = (EW + 1) / 2 + 1;
   localparam int unsigned SW = 2 * DW;
   localparam int unsigned CW = $clog2(EW);
   localparam int unsigned OW = RSP_DIVISOR_WIDTH;

   logic [EW-1:0]  value_ff, value_in;
   logic [DW-1:0]  div_ff, div_in;
   logic [SW-1:0]  sq_ff, sq_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           prime_ff, prime_in;
   logic [OW-1:0]  ldiv_ff, ldiv_in;

   logic [DW:0]    trial;
   logic [DW:0]    div_ext;
   logic [DW:0]    diff;
   logic [SW-1:0]  value_ext;
   logic [DW+OW-1:0] div_wide;

   assign trial     = {rem_ff, value_ff[cnt_ff]};
   assign div_ext   = {1'b0, div_ff};
   assign diff      = trial - div_ext;
   assign value_ext = {{(SW-EW){1'b0}}, value_ff};
   assign div_wide  = {{OW{1'b0}}, div_ff};

   assign status.below_two = (value_ff < EW'(FIRST_DIVISOR));
   assign status.past_root = (sq_ff > value_ext);
   assign status.div_last  = (cnt_ff == '0);
   assign status.rem_zero  = (rem_ff == '0);

   always_comb begin
      value_in = value_ff;
      div_in   = div_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      prime_in = prime_ff;
      ldiv_in  = ldiv_ff;
      if (cmd.load) begin
         value_in = req_number[EW-1:0];
         div_in   = DW'(FIRST_DIVISOR);
         sq_in    = SW'(FIRST_DIVISOR * FIRST_DIVISOR);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         cnt_in = CW'(EW - 1);
      end
      if (cmd.div_step) begin
         if (trial >= div_ext) begin
            rem_in = diff[DW-1:0];
         end else begin
            rem_in = trial[DW-1:0];
         end
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.next_div) begin
         div_in = div_ff + DW'(1);
         sq_in  = sq_ff + {{(SW-DW-1){1'b0}}, div_ff, 1'b1};
      end
      if (cmd.out_load) begin
         prime_in = cmd.out_prime;
         if (cmd.out_prime || status.below_two) begin
            ldiv_in = '0;
         end else begin
            ldiv_in = div_wide[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      prime_ff <= prime_in;
      ldiv_ff  <= ldiv_in;
   end

   assign rsp_is_prime      = prime_ff;
   assign rsp_least_divisor = ldiv_ff;

   a_start_clears_rem: assert property (@(posedge clock)
      cmd.div_start |=> (rem_ff == '0))
      else $error("remainder not cleared at divide start");

endmodule

`default_nettype wire

[src/tdp_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

module tdp_controller
   import tdp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire tdp_status_type  status,
   output tdp_cmd_type          cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_TEST,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      prime_ff, prime_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      prime_in     = prime_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.out_prime = prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.below_two) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else if (status.past_root) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (status.rem_zero) begin
               prime_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prime_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prime_ff     <= prime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_divisor_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) && status.rem_zero |=> (state_ff == ST_FINISH) && !prime_ff)
      else $error("exact divisor did not end the search");

   a_small_not_prime: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) && status.below_two |=> (state_ff == ST_FINISH) && !prime_ff)
      else $error("number below two not reported as composite");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result word loaded without valid");

endmodule

`default_nettype wire

[src/trial_division_prime_test_unit.sv]
// Trial division primality tester.
// req channel: one word per number (req_number). Only the low NUM_WIDTH bits
// are tested. req_ready is high only while the unit is idle.
// rsp channel: one word per number: rsp_is_prime and rsp_least_divisor, the
// smallest divisor from 2 upward, or 0 for a prime and for 0 and 1.
// Each candidate divisor d goes through one root check (d*d kept as a running
// square), a bit-serial remainder over the EW tested bits (EW being the tested
// width, NUM_WIDTH, at most 32) and one remainder test.
// The search tries up to isqrt(number) - 1 candidates; a divisor ends it
// early. The next word is accepted the cycle after the result is placed in
// the output register.
// Reset clears the controller and drops rsp_valid; no clearing pass.
// A stalled receiver holds the result in the output register; the unit
// still takes and works a new word, and waits only to hand over its result.
`timescale 1ns / 1ps
`default_nettype none

module trial_division_prime_test_unit
   import tdp_pkg::*;
#(
   parameter int unsigned NUM_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [REQ_NUMBER_WIDTH-1:0]  req_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_is_prime,
   output logic [RSP_DIVISOR_WIDTH-1:0]      rsp_least_divisor
);

   tdp_cmd_type    cmd;
   tdp_status_type status;

   tdp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tdp_datapath #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_dp (
      .clock             (clock),
      .req_number        (req_number),
      .cmd               (cmd),
      .status            (status),
      .rsp_is_prime      (rsp_is_prime),
      .rsp_least_divisor (rsp_least_divisor)
   );

   a_prime_no_divisor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_prime |-> (rsp_least_divisor == '0))
      else $error("prime word carries a divisor");

endmodule

`default_nettype wire

[tb/tdp_prime_checker.sv]
`timescale 1ns / 1ps

module tdp_prime_checker
   import tdp_pkg::*;
#(
   parameter int unsigned NUM_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [REQ_NUMBER_WIDTH-1:0]  req_number,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_is_prime,
   input  logic [RSP_DIVISOR_WIDTH-1:0] rsp_least_divisor,
   output int                           fail_count,
   output int                           verdicts_pending
);

   typedef struct packed {
      logic                         is_prime;
      logic [RSP_DIVISOR_WIDTH-1:0] least_divisor;
   } verdict_type;

   verdict_type verdict_q[$];

   // smallest factor from 2 up to the integer square root, else prime; 0 and 1 are neither
   function automatic verdict_type trial_divide(logic [REQ_NUMBER_WIDTH-1:0] number);
      bit [63:0]   width_mask;
      bit [63:0]   value;
      bit [63:0]   divisor;
      verdict_type verdict;
      width_mask = ((64'd1 << (NUM_WIDTH - 1)) << 1) - 64'd1;
      value = {32'd0, number} & width_mask;
      verdict = '0;
      if (value >= FIRST_DIVISOR) begin
         divisor = FIRST_DIVISOR;
         while (divisor <= value / divisor && value % divisor != 0)
            divisor++;
         if (divisor <= value / divisor)
            verdict.least_divisor = divisor[RSP_DIVISOR_WIDTH-1:0];
         else
            verdict.is_prime = 1'b1;
      end
      return verdict;
   endfunction

   initial begin
      fail_count = 0;
      verdicts_pending = 0;
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            verdict_q.push_back(trial_divide(req_number));
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected word is_prime=%0d least_divisor=%0d", $time,
                        rsp_is_prime, rsp_least_divisor);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_is_prime !== want.is_prime) begin
                  $display("%0t: is_prime expected %0d actual %0d", $time,
                           want.is_prime, rsp_is_prime);
                  fail_count++;
               end
               if (rsp_least_divisor !== want.least_divisor) begin
                  $display("%0t: least_divisor expected %0d actual %0d", $time,
                           want.least_divisor, rsp_least_divisor);
                  fail_count++;
               end
            end
         end
         verdicts_pending = verdict_q.size();
      end
   end

endmodule

[tb/tb_trial_division_prime_test_unit.sv]
`timescale 1ns / 1ps

module tb_trial_division_prime_test_unit;
   import tdp_pkg::*;

   localparam int unsigned NUM_WIDTH = 32;
   localparam int RANDOM_COUNT = 82;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int DIRECTED_COUNT = 18;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [REQ_NUMBER_WIDTH-1:0]  req_number;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_is_prime;
   logic [RSP_DIVISOR_WIDTH-1:0] rsp_least_divisor;
   int                           fail_count;
   int                           verdicts_pending;
   int                           cycle_count;
   bit                           sender_steady;
   bit                           receiver_steady;

   logic [31:0] directed_numbers [DIRECTED_COUNT] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
      32'd10403, 32'd63001, 32'd65521, 32'd1000003, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
      32'h8000_0000, 32'h8000_0001
   };
   int unsigned small_primes [6] = '{2, 3, 5, 7, 11, 13};

   trial_division_prime_test_unit #(
      .NUM_WIDTH(NUM_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_prime(rsp_is_prime),
      .rsp_least_divisor(rsp_least_divisor)
   );

   tdp_prime_checker #(
      .NUM_WIDTH(NUM_WIDTH)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_number(req_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_prime(rsp_is_prime),
      .rsp_least_divisor(rsp_least_divisor),
      .fail_count(fail_count),
      .verdicts_pending(verdicts_pending)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic send_number(input logic [31:0] number, input int index);
      int gap;
      if (index % 16 == 0)
         sender_steady = ($urandom_range(0, 3) == 0);
      gap = sender_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_number <= number;
      do @(posedge clock); while (!req_ready);
   endtask

   // mostly small numbers; wide ones get a small factor to keep the search short
   function automatic logic [31:0] random_number();
      int unsigned pick;
      int unsigned factor;
      logic [31:0] number;
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
         number = $urandom_range(0, 1023);
      end else if (pick == 2) begin
         number = $urandom_range(0, 65535);
      end else begin
         factor = small_primes[$urandom_range(0, 5)];
         number = $urandom();
         number = number - (number % factor);
      end
      return number;
   endfunction

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_number = '0;
      rsp_ready = 1'b0;
      sender_steady = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_number(directed_numbers[i], i);
      for (int i = 0; i < RANDOM_COUNT; i++)
         send_number(random_number(), DIRECTED_COUNT + i);
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && verdicts_pending == 0)
         $display("tb_trial_division_prime_test_unit passed");
      else
         $display("tb_trial_division_prime_test_unit failed");
      $finish;
   end

   initial begin
      int stall;
      int taken;
      taken = 0;
      receiver_steady = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (taken % 16 == 0)
            receiver_steady = ($urandom_range(0, 3) == 0);
         stall = receiver_steady ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_trial_division_prime_test_unit failed");
      $finish;
   end

endmodule
